>>> rtl/wiggle_sort_median_partition_top_defines.svh
// Assertion macros for the wiggle sort median partition block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef WIGGLE_SORT_MEDIAN_PARTITION_TOP_DEFINES_SVH
`define WIGGLE_SORT_MEDIAN_PARTITION_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WSMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Checks that a condition never holds.
`define WSMP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

>>> rtl/wsmp_pkg.sv
// Shared types and constants for the wiggle sort median partition block.
// No dependencies.
package wsmp_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam int IDX_W = 8;

  typedef logic signed [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // One write into the element store.
  typedef struct packed {
    logic             we;
    idx_t             addr;
    logic [VAL_W-1:0] data;
  } wr_t;

  // One loaded set handed from the loader to the sequencer.
  typedef struct packed {
    logic valid;
    cnt_t n;
    logic ovf;
  } job_t;

  // Status from the sequencer back to the loader.
  typedef struct packed {
    logic take;
    logic done;
  } back_st_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEL_INIT, ST_SEL_LOOP, ST_SP_PIV, ST_SP_PIVD, ST_SP_LOOP,
    ST_SP_CMP, ST_SP_END, ST_SEL_AFTER, ST_SEL_RES, ST_PT_INIT, ST_PT_LOOP,
    ST_PT_CMP, ST_EM_RD, ST_EM_WAIT, ST_EM_HOLD, ST_SWR, ST_SWD, ST_SWW
  } back_state_e;

endpackage

>>> rtl/wsmp_if.sv
// Request channels of the wiggle sort median partition block.
// Depends on wsmp_pkg.
interface wsmp_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [wsmp_pkg::VAL_W-1:0] value;
  logic                          last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface wsmp_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [wsmp_pkg::VAL_W-1:0] value_res;
  logic                          last_res;
  logic                          overflow;
  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

>>> rtl/wsmp_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module wsmp_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [W-1:0]             rdata_a_o,
  output logic [W-1:0]             rdata_b_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_a_q;
  logic [W-1:0] rdata_b_q;

  // Write and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/wsmp_front.sv
// Loader: accepts requests, stores elements, hands each finished set on.
// Depends on wsmp_pkg and wsmp_if.
module wsmp_front #(
  parameter int MAX_N = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  wsmp_in_if.sink             in_i,
  input  wsmp_pkg::back_st_t  bst_i,
  output wsmp_pkg::job_t      job_o,
  output wsmp_pkg::wr_t       wr_o,
  output logic                busy_o
);

  wsmp_pkg::cnt_t cnt_q, cnt_d;
  logic           drop_q, drop_d;
  logic           busy_q, busy_d;
  wsmp_pkg::job_t job_q, job_d;
  logic           acc;
  logic           full;

  assign in_i.ready = !busy_q;
  assign acc        = in_i.valid && !busy_q;
  assign full       = (cnt_q >= wsmp_pkg::cnt_t'(MAX_N));

  // Store write for an accepted element while space remains.
  always_comb begin
    wr_o.we   = acc && !full;
    wr_o.addr = wsmp_pkg::idx_t'({1'b0, cnt_q});
    wr_o.data = in_i.value;
  end

  // Count, drop flag and the one-deep set queue.
  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    busy_d = busy_q;
    job_d  = job_q;
    if (bst_i.take) begin
      job_d.valid = 1'b0;
    end
    if (bst_i.done) begin
      busy_d = 1'b0;
    end
    if (acc) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      if (in_i.last) begin
        job_d.valid = 1'b1;
        job_d.n     = full ? cnt_q : cnt_q + 1'b1;
        job_d.ovf   = drop_q || full;
        busy_d      = 1'b1;
        cnt_d       = '0;
        drop_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
      busy_q <= 1'b0;
      job_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
      busy_q <= busy_d;
      job_q  <= job_d;
    end
  end

  assign job_o  = job_q;
  assign busy_o = busy_q;

endmodule

>>> rtl/wsmp_back.sv
// Sequencer: quickselect for the median, three-way partition, wiggle emission.
// Depends on wsmp_pkg and wsmp_if.
module wsmp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wsmp_pkg::job_t                      job_i,
  output wsmp_pkg::back_st_t                  bst_o,
  output wsmp_pkg::wr_t                       wr_o,
  output wsmp_pkg::idx_t                      raddr_a_o,
  output wsmp_pkg::idx_t                      raddr_b_o,
  input  logic [wsmp_pkg::VAL_W-1:0]          rdata_a_i,
  input  logic [wsmp_pkg::VAL_W-1:0]          rdata_b_i,
  wsmp_out_if.source                          out_o
);

  localparam int VW = wsmp_pkg::VAL_W;

  wsmp_pkg::back_state_e state_q, state_d, ret_q, ret_d;
  wsmp_pkg::idx_t lo_q, lo_d, hi_q, hi_d, kk_q, kk_d, a_q, a_d, b_q, b_d;
  wsmp_pkg::idx_t m_q, m_d, pa_q, pa_d, pb_q, pb_d, slot_q, slot_d;
  wsmp_pkg::idx_t n_q, n_d, half_q, half_d;
  logic [VW-1:0]        pv_q, pv_d, tmp_q, tmp_d, first_q, first_d;
  logic signed [VW+1:0] tm_q, tm_d;
  logic                 second_q, second_d, ovf_q, ovf_d;
  logic [VW-1:0]        ov_q, ov_d;
  logic                 ol_q, ol_d;

  wsmp_pkg::idx_t       len, mm, em_idx;
  logic signed [VW+1:0] x2, va_ext;
  logic                 even;

  assign even   = !n_q[0];
  assign len    = m_q - lo_q + 8'sd1;
  assign x2     = $signed({rdata_a_i[VW-1], rdata_a_i, 1'b0});
  assign va_ext = $signed({{2{rdata_a_i[VW-1]}}, rdata_a_i});
  assign mm     = ($signed(rdata_a_i) > $signed(pv_q)) ? a_q - 8'sd1 : a_q;
  assign em_idx = slot_q[0] ? (slot_q >>> 1) : (slot_q >>> 1) + half_q;

  // Read addresses are set in the state before the one that consumes the registered read data.
  always_comb begin
    raddr_a_o = '0;
    raddr_b_o = '0;
    unique case (state_q)
      wsmp_pkg::ST_SWR:       begin raddr_a_o = pa_q; raddr_b_o = pb_q; end
      wsmp_pkg::ST_SP_PIV:    raddr_a_o = lo_q;
      wsmp_pkg::ST_SP_LOOP:   begin raddr_a_o = a_q; raddr_b_o = b_q; end
      wsmp_pkg::ST_SEL_LOOP:  raddr_a_o = lo_q;
      wsmp_pkg::ST_SEL_AFTER: raddr_a_o = m_q;
      wsmp_pkg::ST_PT_LOOP:   raddr_a_o = a_q;
      wsmp_pkg::ST_EM_RD:     raddr_a_o = em_idx;
      default:                raddr_a_o = '0;
    endcase
  end

  // Next state and datapath updates.
  always_comb begin
    state_d  = state_q;  ret_d   = ret_q;
    lo_d     = lo_q;     hi_d    = hi_q;    kk_d = kk_q;
    a_d      = a_q;      b_d     = b_q;     m_d  = m_q;
    pa_d     = pa_q;     pb_d    = pb_q;    slot_d = slot_q;
    n_d      = n_q;      half_d  = half_q;
    pv_d     = pv_q;     tmp_d   = tmp_q;   first_d = first_q;
    tm_d     = tm_q;     second_d = second_q; ovf_d = ovf_q;
    ov_d     = ov_q;     ol_d    = ol_q;
    bst_o    = '0;
    wr_o     = '0;
    unique case (state_q)
      wsmp_pkg::ST_IDLE: begin
        if (job_i.valid) begin
          bst_o.take = 1'b1;
          n_d        = wsmp_pkg::idx_t'({1'b0, job_i.n});
          half_d     = wsmp_pkg::idx_t'({1'b0, job_i.n}) >>> 1;
          ovf_d      = job_i.ovf;
          second_d   = 1'b0;
          slot_d     = '0;
          if (job_i.n < wsmp_pkg::cnt_t'(2)) begin
            state_d = wsmp_pkg::ST_EM_RD;
          end else begin
            kk_d    = job_i.n[0] ? (wsmp_pkg::idx_t'({1'b0, job_i.n}) >>> 1) + 8'sd1
                                 : (wsmp_pkg::idx_t'({1'b0, job_i.n}) >>> 1);
            state_d = wsmp_pkg::ST_SEL_INIT;
          end
        end
      end
      wsmp_pkg::ST_SEL_INIT: begin
        lo_d    = '0;
        hi_d    = n_q - 8'sd1;
        state_d = wsmp_pkg::ST_SEL_LOOP;
      end
      wsmp_pkg::ST_SEL_LOOP: begin
        if (lo_q < hi_q) begin
          pa_d    = lo_q;
          pb_d    = (lo_q + hi_q) >>> 1;
          ret_d   = wsmp_pkg::ST_SP_PIV;
          state_d = wsmp_pkg::ST_SWR;
        end else begin
          state_d = wsmp_pkg::ST_SEL_RES;
        end
      end
      wsmp_pkg::ST_SP_PIV: state_d = wsmp_pkg::ST_SP_PIVD;
      wsmp_pkg::ST_SP_PIVD: begin
        pv_d    = rdata_a_i;
        a_d     = lo_q + 8'sd1;
        b_d     = hi_q;
        state_d = wsmp_pkg::ST_SP_LOOP;
      end
      wsmp_pkg::ST_SP_LOOP: begin
        state_d = (a_q < b_q) ? wsmp_pkg::ST_SP_CMP : wsmp_pkg::ST_SP_END;
      end
      wsmp_pkg::ST_SP_CMP: begin
        state_d = wsmp_pkg::ST_SP_LOOP;
        if ($signed(rdata_a_i) <= $signed(pv_q)) begin
          a_d = a_q + 8'sd1;
        end else if ($signed(rdata_b_i) >= $signed(pv_q)) begin
          b_d = b_q - 8'sd1;
        end else begin
          pa_d    = a_q;
          pb_d    = b_q;
          ret_d   = wsmp_pkg::ST_SP_LOOP;
          state_d = wsmp_pkg::ST_SWR;
        end
      end
      wsmp_pkg::ST_SP_END: begin
        m_d     = mm;
        pa_d    = mm;
        pb_d    = lo_q;
        ret_d   = wsmp_pkg::ST_SEL_AFTER;
        state_d = wsmp_pkg::ST_SWR;
      end
      wsmp_pkg::ST_SEL_AFTER: begin
        if (kk_q < len) begin
          hi_d    = m_q - 8'sd1;
          state_d = wsmp_pkg::ST_SEL_LOOP;
        end else if (kk_q > len) begin
          kk_d    = kk_q - len;
          lo_d    = m_q + 8'sd1;
          state_d = wsmp_pkg::ST_SEL_LOOP;
        end else begin
          state_d = wsmp_pkg::ST_SEL_RES;
        end
      end
      wsmp_pkg::ST_SEL_RES: begin
        if (even && !second_q) begin
          first_d  = rdata_a_i;
          second_d = 1'b1;
          kk_d     = half_q + 8'sd1;
          state_d  = wsmp_pkg::ST_SEL_INIT;
        end else begin
          tm_d    = even ? $signed({{2{first_q[VW-1]}}, first_q}) + va_ext : x2;
          state_d = wsmp_pkg::ST_PT_INIT;
        end
      end
      wsmp_pkg::ST_PT_INIT: begin
        lo_d    = '0;
        hi_d    = n_q - 8'sd1;
        a_d     = '0;
        state_d = wsmp_pkg::ST_PT_LOOP;
      end
      wsmp_pkg::ST_PT_LOOP: begin
        if (a_q <= hi_q) begin
          state_d = wsmp_pkg::ST_PT_CMP;
        end else begin
          slot_d  = '0;
          state_d = wsmp_pkg::ST_EM_RD;
        end
      end
      wsmp_pkg::ST_PT_CMP: begin
        state_d = wsmp_pkg::ST_PT_LOOP;
        if (x2 > tm_q) begin
          pa_d    = lo_q;
          pb_d    = a_q;
          lo_d    = lo_q + 8'sd1;
          a_d     = a_q + 8'sd1;
          ret_d   = wsmp_pkg::ST_PT_LOOP;
          state_d = wsmp_pkg::ST_SWR;
        end else if (x2 < tm_q) begin
          pa_d    = hi_q;
          pb_d    = a_q;
          hi_d    = hi_q - 8'sd1;
          ret_d   = wsmp_pkg::ST_PT_LOOP;
          state_d = wsmp_pkg::ST_SWR;
        end else begin
          a_d = a_q + 8'sd1;
        end
      end
      wsmp_pkg::ST_EM_RD: state_d = wsmp_pkg::ST_EM_WAIT;
      wsmp_pkg::ST_EM_WAIT: begin
        ov_d    = rdata_a_i;
        ol_d    = (slot_q == n_q - 8'sd1);
        state_d = wsmp_pkg::ST_EM_HOLD;
      end
      wsmp_pkg::ST_EM_HOLD: begin
        if (out_o.ready) begin
          if (ol_q) begin
            bst_o.done = 1'b1;
            state_d    = wsmp_pkg::ST_IDLE;
          end else begin
            slot_d  = slot_q + 8'sd1;
            state_d = wsmp_pkg::ST_EM_RD;
          end
        end
      end
      // Swap of two entries: read both, then write each back crosswise.
      wsmp_pkg::ST_SWR: state_d = wsmp_pkg::ST_SWD;
      wsmp_pkg::ST_SWD: begin
        wr_o.we   = 1'b1;
        wr_o.addr = pa_q;
        wr_o.data = rdata_b_i;
        tmp_d     = rdata_a_i;
        state_d   = wsmp_pkg::ST_SWW;
      end
      wsmp_pkg::ST_SWW: begin
        wr_o.we   = 1'b1;
        wr_o.addr = pb_q;
        wr_o.data = tmp_q;
        state_d   = ret_q;
      end
      default: state_d = wsmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsmp_pkg::ST_IDLE;
      ret_q   <= wsmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;  hi_q <= hi_d;  kk_q <= kk_d;  a_q <= a_d;  b_q <= b_d;
    m_q  <= m_d;   pa_q <= pa_d;  pb_q <= pb_d;  slot_q <= slot_d;
    n_q  <= n_d;   half_q <= half_d;
    pv_q <= pv_d;  tmp_q <= tmp_d; first_q <= first_d; tm_q <= tm_d;
    second_q <= second_d; ovf_q <= ovf_d; ov_q <= ov_d; ol_q <= ol_d;
  end

  assign out_o.valid     = (state_q == wsmp_pkg::ST_EM_HOLD);
  assign out_o.value_res = ov_q;
  assign out_o.last_res  = ol_q;
  assign out_o.overflow  = ovf_q;

endmodule

>>> rtl/wiggle_sort_median_partition_top.sv
// Operation: after the request with last, the sequencer runs quickselect and partition steps,
// with swaps through the store's ports and about twice the selection work for an even count,
// then emits the results one at a time, each held until it is taken.
// Throughput: loading takes one request per cycle while not busy; the next set is loaded only
// after all results of the previous set are taken. Reset: asynchronous, active low; clears
// counts, flags and the sequencer state. Depends on wsmp_pkg, wsmp_if, wsmp_ram, front and back.
`include "wiggle_sort_median_partition_top_defines.svh"
module wiggle_sort_median_partition_top #(
  parameter int MAX_N = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsmp_in_if.sink     in_i,
  wsmp_out_if.source  out_o
);

  localparam int AW = $clog2(MAX_N);

  wsmp_pkg::job_t     job;
  wsmp_pkg::back_st_t bst;
  wsmp_pkg::wr_t      fw, bw, wr;
  wsmp_pkg::idx_t     ra, rb;
  logic [wsmp_pkg::VAL_W-1:0] rda, rdb;
  logic               busy;

  wsmp_front #(.MAX_N(MAX_N)) u_front (
    .clk_i, .rst_ni, .in_i, .bst_i(bst), .job_o(job), .wr_o(fw), .busy_o(busy)
  );

  wsmp_back u_back (
    .clk_i, .rst_ni, .job_i(job), .bst_o(bst), .wr_o(bw),
    .raddr_a_o(ra), .raddr_b_o(rb), .rdata_a_i(rda), .rdata_b_i(rdb), .out_o
  );

  // The loader and the sequencer never write in the same cycle.
  assign wr = fw.we ? fw : bw;

  wsmp_ram #(.W(wsmp_pkg::VAL_W), .DEPTH(MAX_N)) u_store (
    .clk_i,
    .we_i(wr.we),
    .waddr_i(wr.addr[AW-1:0]),
    .wdata_i(wr.data),
    .raddr_a_i(ra[AW-1:0]),
    .raddr_b_i(rb[AW-1:0]),
    .rdata_a_o(rda),
    .rdata_b_o(rdb)
  );

  `WSMP_ASSERT_NEVER(a_wr_excl, fw.we && bw.we)
  `WSMP_ASSERT_IMPL(a_out_owned, out_o.valid, busy && !in_i.ready)
  `WSMP_ASSERT_IMPL(a_take_valid, bst.take, job.valid)

endmodule
